@@ hw/rtl/safs_pkg.sv @@
`default_nettype none

package safs_pkg;

	localparam int NUM_SLOTS  = 1024;
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
	localparam int SUM_W      = CNT_W + 1;

	// live bits are kept as rows, each row with its own valid flop
	localparam int LIVE_ROW_W = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
	localparam int LIVE_ROWS  = NUM_SLOTS / LIVE_ROW_W;
	localparam int ROW_AW     = (LIVE_ROWS > 1) ? $clog2(LIVE_ROWS) : 1;
	localparam int BIT_AW     = $clog2(LIVE_ROW_W);

	localparam int REQ_W  = 3;
	localparam int IDX_W  = 12;
	localparam int OFS_W  = 10;
	localparam int RES_W  = 11;
	localparam int STAT_W = 3;
	localparam int TOT_W  = 11;

	localparam int IN_BITS  = REQ_W + IDX_W + OFS_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = RES_W + STAT_W + 2 * TOT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC    = 3'd0,
		REQ_FREE     = 3'd1,
		REQ_QUERY    = 3'd2,
		REQ_PEEK     = 3'd3,
		REQ_PLACE    = 3'd4,
		REQ_MARK_DEL = 3'd5
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_OOB      = 3'd1,
		ST_NOT_LIVE = 3'd2,
		ST_FULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_e_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_POP,
		FSM_EXEC
	} fsm_e_t;

endpackage

`default_nettype wire

@@ hw/rtl/safs_live.sv @@
`default_nettype none

module safs_live
	import safs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_idx,
	output logic                   rd_bit,
	input  wire logic              wr_en,
	input  wire logic              wr_bit
);

	logic [LIVE_ROW_W-1:0] mem [LIVE_ROWS];
	logic [LIVE_ROWS-1:0]  row_vld_q;
	logic [LIVE_ROW_W-1:0] row_data_q;
	logic                  row_ok_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [ROW_AW-1:0]     rd_row;
	logic [ROW_AW-1:0]     wr_row;
	logic [BIT_AW-1:0]     bit_sel;
	logic [LIVE_ROW_W-1:0] cur_row;
	logic [LIVE_ROW_W-1:0] new_row;

	assign rd_row  = ROW_AW'(rd_idx / LIVE_ROW_W);
	assign wr_row  = ROW_AW'(idx_q / LIVE_ROW_W);
	assign bit_sel = BIT_AW'(idx_q % LIVE_ROW_W);

	// a row never written reads as all zero
	assign cur_row = row_ok_q ? row_data_q : '0;
	assign rd_bit  = cur_row[bit_sel];

	always_comb begin
		new_row          = cur_row;
		new_row[bit_sel] = wr_bit;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_data_q <= mem[rd_row];
		end
		if (wr_en) begin
			mem[wr_row] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			row_ok_q  <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (rd_en) begin
				idx_q    <= rd_idx;
				row_ok_q <= row_vld_q[rd_row];
			end
			if (wr_en) begin
				row_vld_q[wr_row] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/slot_allocator_free_stack.sv @@
`default_nettype none

// channel  dir  fields (lsb first)
// s_*      in   req_type[2:0] slot_index[14:3] peek_offset[24:15], zero pad to 32
// m_*      out  result_index[10:0] status[13:11] live_total[24:14]
//               free_total[35:25], zero pad to 40
//
// one request at a time: IDLE then EXEC, with POP between them for an allocate that pops the stack
// (the popped index must come out of the stack ram before its live row is read)
// both rams have registered reads; write-back happens in EXEC once the output register is free
// reset: live rows flagged invalid at once, no clearing pass, counts zero
// a result waiting on m_tready holds the request in its last cycle

module slot_allocator_free_stack
	import safs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // req_type, slot_index, peek_offset
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata    // result_index, status, live_total, free_total
);

	logic [REQ_W-1:0]  in_req;
	logic [IDX_W-1:0]  in_idx;
	logic [OFS_W-1:0]  in_ofs;

	fsm_e_t            state_q;
	fsm_e_t            state_nxt;
	logic              accept;
	logic              fire;

	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  live_cnt_q;
	logic [REQ_W-1:0]  req_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [OFS_W-1:0]  ofs_s1;
	logic [SLOT_W-1:0] pos_s1;

	logic [SLOT_W-1:0] stk_mem [NUM_SLOTS];
	logic [SLOT_W-1:0] stk_rd_q;
	logic [SLOT_W-1:0] stk_rd_addr;
	logic              stk_wr_en;

	logic              live_rd_en;
	logic [SLOT_W-1:0] live_rd_idx;
	logic              live_bit;
	logic              live_wr_en;
	logic              live_wr_bit;

	logic [CNT_W-1:0]  depth_nxt;
	logic [CNT_W-1:0]  live_nxt;
	logic [SUM_W-1:0]  res_pos;
	status_e_t         status;
	logic [SUM_W-1:0]  high;
	logic [SUM_W-1:0]  peek_pos;
	logic              in_cap;
	logic              oob;
	logic              stk_full;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	assign in_req = s_tdata[REQ_W-1:0];
	assign in_idx = s_tdata[REQ_W+IDX_W-1:REQ_W];
	assign in_ofs = s_tdata[IN_BITS-1:REQ_W+IDX_W];

	assign accept = s_tvalid && s_tready;
	assign fire   = (state_q == FSM_EXEC) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (in_req == REQ_ALLOC && depth_q != '0) begin
						state_nxt = FSM_POP;
					end else begin
						state_nxt = FSM_EXEC;
					end
				end
			end
			FSM_POP: begin
				state_nxt = FSM_EXEC;
			end
			FSM_EXEC: begin
				if (fire) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	// read side control
	always_comb begin
		s_tready    = 1'b0;
		live_rd_en  = 1'b0;
		live_rd_idx = SLOT_W'(in_idx);
		stk_rd_addr = SLOT_W'(depth_q - CNT_W'(1));
		unique case (state_q)
			FSM_IDLE: begin
				s_tready   = 1'b1;
				live_rd_en = accept;
				if (in_req == REQ_ALLOC) begin
					live_rd_idx = SLOT_W'(live_cnt_q);
				end
				if (in_req == REQ_PEEK) begin
					stk_rd_addr = SLOT_W'(depth_q - CNT_W'(in_ofs) - CNT_W'(1));
				end
			end
			FSM_POP: begin
				// popped index now out of the stack ram
				live_rd_en  = 1'b1;
				live_rd_idx = stk_rd_q;
			end
			FSM_EXEC: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
			idx_s1 <= in_idx;
			ofs_s1 <= in_ofs;
			pos_s1 <= SLOT_W'(live_cnt_q);
		end else if (state_q == FSM_POP) begin
			pos_s1 <= stk_rd_q;
		end
	end

	// freed index stack
	always_ff @(posedge clk) begin
		if (accept) begin
			stk_rd_q <= stk_mem[stk_rd_addr];
		end
		if (stk_wr_en) begin
			stk_mem[SLOT_W'(depth_q)] <= SLOT_W'(idx_s1);
		end
	end

	safs_live u_live (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (live_rd_en),
		.rd_idx (live_rd_idx),
		.rd_bit (live_bit),
		.wr_en  (live_wr_en),
		.wr_bit (live_wr_bit)
	);

	assign high     = SUM_W'(live_cnt_q) + SUM_W'(depth_q);
	assign peek_pos = SUM_W'(live_cnt_q) + SUM_W'(ofs_s1);
	assign in_cap   = 32'(idx_s1) < NUM_SLOTS;
	assign oob      = !in_cap || (32'(idx_s1) >= 32'(high));
	assign stk_full = 32'(depth_q) >= NUM_SLOTS;

	// execute: decide, update counts and write back
	always_comb begin
		depth_nxt   = depth_q;
		live_nxt    = live_cnt_q;
		res_pos     = '0;
		status      = ST_OK;
		live_wr_en  = 1'b0;
		live_wr_bit = 1'b0;
		stk_wr_en   = 1'b0;
		unique case (req_s1)
			REQ_ALLOC: begin
				if (depth_q != '0 || 32'(live_cnt_q) < NUM_SLOTS) begin
					if (depth_q != '0) begin
						depth_nxt = depth_q - CNT_W'(1);
					end
					res_pos = SUM_W'(pos_s1);
					if (!live_bit) begin
						live_wr_en  = 1'b1;
						live_wr_bit = 1'b1;
						live_nxt    = live_cnt_q + CNT_W'(1);
					end
				end else begin
					status = ST_FULL;
				end
			end
			REQ_FREE: begin
				if (oob) begin
					status = ST_OOB;
				end else if (!live_bit) begin
					status = ST_NOT_LIVE;
				end else if (stk_full) begin
					status = ST_OVERFLOW;
				end else begin
					stk_wr_en  = 1'b1;
					depth_nxt  = depth_q + CNT_W'(1);
					live_wr_en = 1'b1;
					live_nxt   = live_cnt_q - CNT_W'(1);
				end
			end
			REQ_QUERY: begin
				if (oob) begin
					status = ST_OOB;
				end else if (!live_bit) begin
					status = ST_NOT_LIVE;
				end
			end
			REQ_PEEK: begin
				if (CNT_W'(ofs_s1) < depth_q) begin
					res_pos = SUM_W'(stk_rd_q);
				end else begin
					res_pos = peek_pos;
				end
				if (32'(res_pos) >= NUM_SLOTS) begin
					status = ST_OOB;
				end
			end
			REQ_PLACE: begin
				if (!in_cap) begin
					status = ST_OOB;
				end else if (live_bit) begin
					status = ST_NOT_LIVE;
				end else begin
					live_wr_en  = 1'b1;
					live_wr_bit = 1'b1;
					live_nxt    = live_cnt_q + CNT_W'(1);
				end
			end
			REQ_MARK_DEL: begin
				if (!in_cap) begin
					status = ST_OOB;
				end else if (stk_full) begin
					status = ST_OVERFLOW;
				end else begin
					stk_wr_en = 1'b1;
					depth_nxt = depth_q + CNT_W'(1);
					if (live_bit) begin
						live_wr_en = 1'b1;
						live_nxt   = live_cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
				status = ST_OOB;
			end
		endcase
		if (!fire) begin
			live_wr_en = 1'b0;
			stk_wr_en  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			live_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				depth_q    <= depth_nxt;
				live_cnt_q <= live_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= OUT_W'({TOT_W'(depth_nxt), TOT_W'(live_nxt), status,
				RES_W'(res_pos)});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

@@ bench/slot_allocator_free_stack_tb.sv @@
`timescale 1ns / 100ps

module slot_allocator_free_stack_tb;
	import safs_pkg::*;

	localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;
	localparam int ST_LSB   = RES_W;
	localparam int LIVE_LSB = RES_W + STAT_W;
	localparam int FREE_LSB = LIVE_LSB + TOT_W;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef enum int {
		MIX_CHURN,
		MIX_GROW,
		MIX_PUSH
	} mix_t;

	typedef struct packed {
		logic [RES_W-1:0] slot;
		status_e_t        status;
		logic [TOT_W-1:0] live;
		logic [TOT_W-1:0] stacked;
	} reply_t;

	class slot_ledger;
		bit               live_map [NUM_SLOTS];
		logic [SLOT_W-1:0] freed_ids [NUM_SLOTS];
		int unsigned      depth;
		int unsigned      live_cnt;
		reply_t           replies [$];
		int               errors;

		function new();
			depth = 0;
			live_cnt = 0;
			errors = 0;
		endfunction

		// apply one accepted request to the shadow state and queue its reply
		function void apply_request(logic [REQ_W-1:0] rt, logic [IDX_W-1:0] si,
				logic [OFS_W-1:0] po);
			int unsigned hwm;
			int unsigned pos;
			bit          in_range;
			logic [RES_W-1:0] slot;
			status_e_t   st;
			reply_t      r;
			hwm = live_cnt + depth;
			in_range = si < NUM_SLOTS;
			slot = '0;
			st = ST_OK;
			pos = 0;
			case (rt)
				REQ_ALLOC: begin
					if (depth > 0) begin
						depth--;
						pos = freed_ids[depth];
					end else if (live_cnt < NUM_SLOTS) begin
						pos = live_cnt;
					end else begin
						st = ST_FULL;
					end
					if (st == ST_OK) begin
						// a popped or fresh slot may already be live after place-live
						if (!live_map[pos]) begin
							live_map[pos] = 1'b1;
							live_cnt++;
						end
						slot = pos[RES_W-1:0];
					end
				end
				REQ_FREE: begin
					if (!in_range || si >= hwm)
						st = ST_OOB;
					else if (!live_map[si])
						st = ST_NOT_LIVE;
					else if (depth >= NUM_SLOTS)
						st = ST_OVERFLOW;
					else begin
						freed_ids[depth] = si[SLOT_W-1:0];
						depth++;
						live_map[si] = 1'b0;
						live_cnt--;
					end
				end
				REQ_QUERY: begin
					if (!in_range || si >= hwm)
						st = ST_OOB;
					else if (!live_map[si])
						st = ST_NOT_LIVE;
				end
				REQ_PEEK: begin
					if (po < depth)
						pos = freed_ids[depth - po - 1];
					else
						pos = live_cnt + po;
					slot = pos[RES_W-1:0];
					if (pos >= NUM_SLOTS)
						st = ST_OOB;
				end
				REQ_PLACE: begin
					if (!in_range)
						st = ST_OOB;
					else if (live_map[si])
						st = ST_NOT_LIVE;
					else begin
						live_map[si] = 1'b1;
						live_cnt++;
					end
				end
				REQ_MARK_DEL: begin
					if (!in_range)
						st = ST_OOB;
					else if (depth >= NUM_SLOTS)
						st = ST_OVERFLOW;
					else begin
						// pushed even when already stacked
						freed_ids[depth] = si[SLOT_W-1:0];
						depth++;
						if (live_map[si]) begin
							live_map[si] = 1'b0;
							live_cnt--;
						end
					end
				end
				default: begin
					st = ST_OOB;
				end
			endcase
			r.slot = slot;
			r.status = st;
			r.live = live_cnt[TOT_W-1:0];
			r.stacked = depth[TOT_W-1:0];
			replies.push_back(r);
		endfunction

		function void check_reply(logic [OUT_W-1:0] d);
			reply_t want;
			if (replies.size() == 0) begin
				$error("result with no request outstanding: %h", d);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (d[RES_W-1:0] !== want.slot) begin
				$error("result_index: expected %0d, actual %0d", want.slot, d[RES_W-1:0]);
				errors++;
			end
			if (d[ST_LSB +: STAT_W] !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, d[ST_LSB +: STAT_W]);
				errors++;
			end
			if (d[LIVE_LSB +: TOT_W] !== want.live) begin
				$error("live_total: expected %0d, actual %0d", want.live, d[LIVE_LSB +: TOT_W]);
				errors++;
			end
			if (d[FREE_LSB +: TOT_W] !== want.stacked) begin
				$error("free_total: expected %0d, actual %0d", want.stacked,
					d[FREE_LSB +: TOT_W]);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // req_type, slot_index, peek_offset
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // result_index, status, live_total, free_total

	slot_ledger sb;
	int         send_gap_pct;
	int         take_gap_pct;
	bit         hold_off_pending = 1'b0;
	int         hold_left = 0;

	slot_allocator_free_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: check on handshake, then choose next ready
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_reply(m_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_off_pending) begin
			hold_off_pending = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= take_gap_pct);
		end
	end

	task automatic send_request(input logic [REQ_W-1:0] rt, input logic [IDX_W-1:0] si,
			input logic [OFS_W-1:0] po);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - IN_BITS){1'b0}}, po, si, rt};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.apply_request(rt, si, po);
	endtask

	function automatic logic [IDX_W-1:0] pick_live_slot();
		int unsigned span;
		int unsigned cand;
		span = sb.live_cnt + sb.depth;
		if (span > NUM_SLOTS)
			span = NUM_SLOTS;
		if (span == 0)
			span = 1;
		cand = $urandom_range(span - 1);
		// a few retries so most frees land on a live slot
		for (int k = 0; k < 16 && !sb.live_map[cand]; k++)
			cand = $urandom_range(span - 1);
		return cand[IDX_W-1:0];
	endfunction

	task automatic send_random(input mix_t mix);
		logic [31:0]      r1;
		logic [31:0]      r2;
		int unsigned      pick;
		logic [REQ_W-1:0] rt;
		logic [IDX_W-1:0] si;
		logic [OFS_W-1:0] po;
		r1 = $urandom;
		r2 = $urandom;
		pick = $urandom_range(99);
		rt = REQ_ALLOC;
		si = r1[IDX_W-1:0];
		po = r2[OFS_W-1:0];
		case (mix)
			MIX_GROW: begin
				if (pick < 10) begin
					rt = REQ_PLACE;
					si[IDX_W-1:SLOT_W] = '0;
				end else if (pick < 15) begin
					rt = REQ_FREE;
					si = pick_live_slot();
				end else if (pick < 20) begin
					rt = REQ_QUERY;
				end else if (pick < 25) begin
					rt = REQ_PEEK;
					po[OFS_W-1:4] = '0;
				end
			end
			MIX_PUSH: begin
				if (pick < 88) begin
					rt = REQ_MARK_DEL;
					if (r2[31:28] != 4'd0)
						si[IDX_W-1:SLOT_W] = '0;
				end else if (pick < 94) begin
					rt = REQ_PEEK;
					po[OFS_W-1:5] = '0;
				end else if (pick < 97) begin
					rt = REQ_QUERY;
				end
			end
			default: begin
				if (pick < 20) begin
					rt = REQ_FREE;
					if (r2[31:29] != 3'd0)
						si = pick_live_slot();
				end else if (pick < 30) begin
					rt = REQ_QUERY;
					if (r2[31])
						si[IDX_W-1:SLOT_W] = '0;
				end else if (pick < 40) begin
					rt = REQ_PEEK;
					if (r2[30])
						po[OFS_W-1:4] = '0;
				end else if (pick < 48) begin
					rt = REQ_PLACE;
					if (r2[29])
						si[IDX_W-1:SLOT_W] = '0;
				end else if (pick < 62) begin
					rt = REQ_MARK_DEL;
					if (r2[28])
						si[IDX_W-1:SLOT_W] = '0;
				end else if (pick < 70) begin
					// noise, reserved codes included
					rt = r1[31:29];
				end
			end
		endcase
		send_request(rt, si, po);
	endtask

	initial begin
		sb = new();
		send_gap_pct = 26;
		take_gap_pct = 83;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_QUERY, 12'd1, 10'd0);
		send_request(REQ_FREE, 12'd1, 10'd0);
		send_request(REQ_FREE, 12'd1, 10'd0);
		send_request(REQ_QUERY, 12'd1, 10'd0);
		send_request(REQ_FREE, 12'd4095, 10'd1023);
		// in capacity but above the high water mark
		send_request(REQ_FREE, 12'd500, 10'd0);
		send_request(REQ_QUERY, 12'd4095, 10'd0);
		send_request(REQ_PEEK, 12'd0, 10'd0);
		send_request(REQ_PEEK, 12'd0, 10'd1023);
		send_request(REQ_PLACE, 12'd4095, 10'd0);
		send_request(REQ_PLACE, 12'd1023, 10'd0);
		send_request(REQ_PLACE, 12'd1023, 10'd0);
		send_request(REQ_MARK_DEL, 12'd4095, 10'd0);
		send_request(REQ_MARK_DEL, 12'd2, 10'd0);
		send_request(REQ_MARK_DEL, 12'd2, 10'd0);
		// pops 2 twice: second time the slot is already live
		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_ALLOC, 12'd0, 10'd0);
		send_request(REQ_RSVD_LO, 12'd4095, 10'd1023);
		send_request(REQ_RSVD_HI, 12'd0, 10'd0);
		send_request(REQ_QUERY, 12'd0, 10'd0);

		// long receiver stall while requests keep coming
		hold_off_pending = 1'b1;
		repeat (100) send_random(MIX_CHURN);

		// fill every slot, then hit the full case
		for (int k = 0; k < 1600; k++) begin
			if (sb.live_cnt == NUM_SLOTS && sb.depth == 0)
				break;
			send_random(MIX_GROW);
		end
		repeat (15) send_random(MIX_GROW);

		send_gap_pct = 83;
		take_gap_pct = 26;
		// deepen the freed stack
		repeat (80) send_random(MIX_PUSH);

		send_gap_pct = 0;
		take_gap_pct = 0;
		repeat (100) send_random(MIX_CHURN);

		s_tvalid <= 1'b0;
		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ slot_allocator_free_stack.f @@
hw/rtl/safs_pkg.sv
hw/rtl/safs_live.sv
hw/rtl/slot_allocator_free_stack.sv
bench/slot_allocator_free_stack_tb.sv
